// ===== design/page_replacement_fifo_lru_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the page replacement block
// Shorthand for clocked assertions that are muted while reset is held.
// ----------------------------------------------------------------------------
`ifndef PAGE_REPLACEMENT_FIFO_LRU_MACROS_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_MACROS_SVH

// A property that is checked at every clock edge outside reset.
`define PRFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A property that must hold in the cycle after the trigger.
`define PRFL_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ===== design/prfl_pkg.sv =====
// ----------------------------------------------------------------------------
// prfl_pkg
// Constants, control word layout and microcode table of the page replacement
// block.
// ----------------------------------------------------------------------------
package prfl_pkg;

  // Table size and stored page width.
  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 32;

  // Derived widths: frame index, and a count that can hold FRAMES itself.
  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  // Port field widths.
  localparam int PAGE_W      = 32;
  localparam int FRAME_OUT_W = 4;
  localparam int STAT_W      = 32;
  localparam int NUMF_W      = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + FRAME_OUT_W + 1 + PAGE_W + 2 * STAT_W);

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 1'b1;
  localparam logic [NUMF_W-1:0]    NUM_FRAMES_RST = 5'd16;

  // Replacement policies.
  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  // Sequencer steps.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] ST_SCAN  = 3'd1;
  localparam logic [STEP_W-1:0] ST_DRAIN = 3'd2;
  localparam logic [STEP_W-1:0] ST_MOD   = 3'd3;
  localparam logic [STEP_W-1:0] ST_PICK  = 3'd4;
  localparam logic [STEP_W-1:0] ST_EVRD  = 3'd5;
  localparam logic [STEP_W-1:0] ST_WAIT  = 3'd6;
  localparam logic [STEP_W-1:0] ST_UPD   = 3'd7;

  // Jump conditions: when true the sequencer goes to the target step.
  localparam int JC_W = 3;
  localparam logic [JC_W-1:0] JC_NEXT      = 3'd0;
  localparam logic [JC_W-1:0] JC_GOTO      = 3'd1;
  localparam logic [JC_W-1:0] JC_NO_IN     = 3'd2;
  localparam logic [JC_W-1:0] JC_SCAN_MORE = 3'd3;
  localparam logic [JC_W-1:0] JC_MOD_MORE  = 3'd4;
  localparam logic [JC_W-1:0] JC_OUT_BUSY  = 3'd5;

  // One control word of the microcode.
  typedef struct packed {
    logic [JC_W-1:0]   jc;
    logic [STEP_W-1:0] target;
    logic              idle;
    logic              scan;
    logic              mod_step;
    logic              pick;
    logic              ev_rd;
    logic              commit;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic scan_more;
    logic mod_more;
  } dp_stat_t;

  // All branch conditions seen by the sequencer.
  typedef struct packed {
    logic in_fire;
    logic scan_more;
    logic mod_more;
    logic out_busy;
  } cond_t;

  // One result item.
  typedef struct packed {
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [STAT_W-1:0]      fault_count;
    logic [STAT_W-1:0]      write_count;
  } result_t;

  // Microcode table.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    unique case (step)
      ST_IDLE: begin
        w.jc     = JC_NO_IN;
        w.target = ST_IDLE;
        w.idle   = 1'b1;
      end
      ST_SCAN: begin
        w.jc     = JC_SCAN_MORE;
        w.target = ST_SCAN;
        w.scan   = 1'b1;
      end
      ST_DRAIN: begin
        w.jc     = JC_NEXT;
        w.target = ST_MOD;
      end
      ST_MOD: begin
        w.jc       = JC_MOD_MORE;
        w.target   = ST_MOD;
        w.mod_step = 1'b1;
      end
      ST_PICK: begin
        w.jc     = JC_NEXT;
        w.target = ST_EVRD;
        w.pick   = 1'b1;
      end
      ST_EVRD: begin
        w.jc     = JC_NEXT;
        w.target = ST_WAIT;
        w.ev_rd  = 1'b1;
      end
      ST_WAIT: begin
        w.jc     = JC_OUT_BUSY;
        w.target = ST_WAIT;
      end
      ST_UPD: begin
        w.jc     = JC_GOTO;
        w.target = ST_IDLE;
        w.commit = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/page_replacement_fifo_lru.sv =====
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru
// Page replacement block: fully associative frame table with FIFO and
// least-recently-used replacement, saturating fault and write counters.
// ----------------------------------------------------------------------------
// An access goes from acceptance through the scan of the frames in use, a
// drain step, the pointer reduction, the pick, the eviction read and the
// wait to commit, and a new item is accepted only when the block is idle.
// The scan reads the frame memory one frame per cycle; after the frame count
// has been lowered, a FIFO fault repeats the reduction step until the pointer
// lies below the frame count. The commit also waits for as long as the
// output register still holds an earlier result that has not been taken.
// The result sits in an output register, and the next item is accepted in
// the cycle after commit while that result still waits to be taken.

module page_replacement_fifo_lru (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input items.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [prfl_pkg::PAGE_W-1:0]          in_tdata,   // [31:0] page_number
  input  logic                                 in_tuser,   // [0] is_write
  // Result items.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] hit, [4:1] frame_index, [5] evicted_valid, [37:6] evicted_page,
  // [69:38] fault_count, [101:70] write_count, [103:102] zero
  output logic [prfl_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Configuration writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [prfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prfl_pkg::NUMF_W-1:0]          cfg_data
);

  prfl_pkg::ctrl_t    ctrl;
  prfl_pkg::cond_t    cond;
  prfl_pkg::dp_stat_t stat;
  prfl_pkg::result_t  res;
  prfl_pkg::result_t  res_r;

  logic [prfl_pkg::NUMF_W-1:0] num_frames_r;
  logic                        policy_r;
  logic                        out_valid_r;
  logic                        in_fire;

  assign in_tready = ctrl.idle;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Branch conditions for the sequencer.
  assign cond.in_fire   = in_fire;
  assign cond.scan_more = stat.scan_more;
  assign cond.mod_more  = stat.mod_more;
  assign cond.out_busy  = out_valid_r && !out_tready;

  prfl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctrl  (ctrl)
  );

  prfl_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .in_fire     (in_fire),
    .in_page     (in_tdata),
    .in_is_write (in_tuser),
    .num_frames  (num_frames_r),
    .policy      (policy_r),
    .stat        (stat),
    .res         (res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_frames_r <= prfl_pkg::NUM_FRAMES_RST;
      policy_r     <= prfl_pkg::POL_FIFO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        prfl_pkg::REG_NUM_FRAMES: num_frames_r <= cfg_data;
        prfl_pkg::REG_POLICY:     policy_r     <= cfg_data[0];
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{prfl_pkg::OUT_PAD_W{1'b0}}, res_r.write_count, res_r.fault_count,
                       res_r.evicted_page, res_r.evicted_valid, res_r.frame_index,
                       res_r.hit};

endmodule

// ===== design/prfl_seq.sv =====
// ----------------------------------------------------------------------------
// prfl_seq
// Step counter and microcode lookup with conditional jumps.
// ----------------------------------------------------------------------------
`include "page_replacement_fifo_lru_macros.svh"

module prfl_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  prfl_pkg::cond_t   cond,
  output prfl_pkg::ctrl_t   ctrl
);

  logic [prfl_pkg::STEP_W-1:0] step_r;
  logic [prfl_pkg::STEP_W-1:0] step_nxt;
  logic                        take;

  // The control word of the current step.
  assign ctrl = prfl_pkg::ucode(step_r);

  // Branch decision.
  always_comb begin
    unique case (ctrl.jc)
      prfl_pkg::JC_NEXT:      take = 1'b0;
      prfl_pkg::JC_GOTO:      take = 1'b1;
      prfl_pkg::JC_NO_IN:     take = !cond.in_fire;
      prfl_pkg::JC_SCAN_MORE: take = cond.scan_more;
      prfl_pkg::JC_MOD_MORE:  take = cond.mod_more;
      prfl_pkg::JC_OUT_BUSY:  take = cond.out_busy;
      default:                take = 1'b0;
    endcase
    step_nxt = take ? ctrl.target : step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= prfl_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // A commit always returns the sequencer to the idle step.
  `PRFL_ASSERT_NEXT(a_commit_to_idle, ctrl.commit, step_r == prfl_pkg::ST_IDLE, "commit did not return to idle")
  // An accepted item always starts the scan.
  `PRFL_ASSERT_NEXT(a_fire_to_scan, ctrl.idle && cond.in_fire, step_r == prfl_pkg::ST_SCAN, "accepted item did not start a scan")
  // The sequencer waits only while the output register holds a result not yet taken.
  `PRFL_ASSERT(a_wait_busy, (step_r == prfl_pkg::ST_WAIT && !cond.out_busy) |=> step_r == prfl_pkg::ST_UPD, "wait step held with a free output")

endmodule

// ===== design/prfl_dp.sv =====
// ----------------------------------------------------------------------------
// prfl_dp
// Frame table datapath: page memory, valid bits, recency ranks, FIFO pointer,
// counters and the compare unit, all driven by the control word.
// ----------------------------------------------------------------------------
`include "page_replacement_fifo_lru_macros.svh"

module prfl_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prfl_pkg::ctrl_t               ctrl,
  input  logic                          in_fire,
  input  logic [prfl_pkg::PAGE_W-1:0]   in_page,
  input  logic                          in_is_write,
  input  logic [prfl_pkg::NUMF_W-1:0]   num_frames,
  input  logic                          policy,
  output prfl_pkg::dp_stat_t            stat,
  output prfl_pkg::result_t             res
);

  // Frame memory, one read port with registered data.
  logic [prfl_pkg::PAGE_BITS-1:0] page_mem [prfl_pkg::FRAMES];
  logic [prfl_pkg::PAGE_BITS-1:0] rd_page_r;

  // Architectural state.
  logic [prfl_pkg::FRAMES-1:0]  valid_r;
  logic [prfl_pkg::FIDX_W-1:0]  rank_r [prfl_pkg::FRAMES];
  logic [prfl_pkg::FIDX_W-1:0]  fifo_ptr_r;
  logic [prfl_pkg::FIDX_W-1:0]  fifo_ptr_nxt;
  logic [prfl_pkg::STAT_W-1:0]  faults_r;
  logic [prfl_pkg::STAT_W-1:0]  faults_inc;
  logic [prfl_pkg::STAT_W-1:0]  writes_r;

  // Per-item working registers.
  logic [prfl_pkg::PAGE_BITS-1:0] page_r;
  logic [prfl_pkg::CNT_W-1:0]     k_r;
  logic                           cmp_en_r;
  logic [prfl_pkg::FIDX_W-1:0]    cmp_idx_r;
  logic                           hit_r;
  logic [prfl_pkg::FIDX_W-1:0]    hit_idx_r;
  logic                           inv_found_r;
  logic [prfl_pkg::FIDX_W-1:0]    inv_idx_r;
  logic [prfl_pkg::FIDX_W-1:0]    min_idx_r;
  logic [prfl_pkg::FIDX_W-1:0]    min_rank_r;
  logic [prfl_pkg::FIDX_W-1:0]    victim_r;
  logic [prfl_pkg::FIDX_W-1:0]    frame_r;
  logic                           ev_valid_r;

  logic [prfl_pkg::CNT_W-1:0]     n;
  logic                           load;
  logic                           mem_re;
  logic                           mem_we;
  logic [prfl_pkg::FIDX_W-1:0]    rd_addr;
  logic [prfl_pkg::FIDX_W-1:0]    rank_addr;
  logic [prfl_pkg::FIDX_W-1:0]    rank_rd;
  logic [prfl_pkg::FIDX_W-1:0]    valid_addr;
  logic                           valid_rd;
  logic [prfl_pkg::FRAMES-1:0]    top_rank;

  // Frames in use: zero acts as one, anything above the table as the table.
  always_comb begin
    if (num_frames == '0) begin
      n = prfl_pkg::CNT_W'(1);
    end else if (32'(num_frames) > prfl_pkg::FRAMES) begin
      n = prfl_pkg::CNT_W'(prfl_pkg::FRAMES);
    end else begin
      n = prfl_pkg::CNT_W'(num_frames);
    end
  end

  assign load   = ctrl.idle && in_fire;
  assign mem_re = ctrl.scan || ctrl.ev_rd;
  assign mem_we = ctrl.commit && !hit_r;

  // Shared read addresses of the memory, the ranks and the valid bits.
  assign rd_addr    = ctrl.scan ? k_r[prfl_pkg::FIDX_W-1:0] : frame_r;
  assign rank_addr  = ctrl.commit ? frame_r : cmp_idx_r;
  assign rank_rd    = rank_r[rank_addr];
  assign valid_addr = ctrl.ev_rd ? frame_r : cmp_idx_r;
  assign valid_rd   = valid_r[valid_addr];

  // Branch status for the sequencer.
  assign stat.scan_more = (k_r + prfl_pkg::CNT_W'(1)) < n;
  assign stat.mod_more  = !hit_r && (policy == prfl_pkg::POL_FIFO) &&
                          (prfl_pkg::CNT_W'(victim_r) >= n);

  // Saturating fault count and the FIFO pointer after a fault.
  assign faults_inc   = (faults_r == '1) ? faults_r : faults_r + 1'b1;
  assign fifo_ptr_nxt = ((prfl_pkg::CNT_W'(frame_r) + prfl_pkg::CNT_W'(1)) == n) ? '0 :
                        prfl_pkg::FIDX_W'(prfl_pkg::CNT_W'(frame_r) + prfl_pkg::CNT_W'(1));

  // Frame page memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[frame_r] <= page_r;
    end
    if (mem_re) begin
      rd_page_r <= page_mem[rd_addr];
    end
  end

  // Item working registers: search results, victim choice.
  always_ff @(posedge clk) begin
    if (load) begin
      page_r      <= in_page[prfl_pkg::PAGE_BITS-1:0];
      k_r         <= '0;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
      inv_found_r <= 1'b0;
      inv_idx_r   <= '0;
      min_idx_r   <= '0;
      min_rank_r  <= '1;
      victim_r    <= fifo_ptr_r;
    end
    if (ctrl.scan) begin
      k_r       <= k_r + 1'b1;
      cmp_idx_r <= k_r[prfl_pkg::FIDX_W-1:0];
    end
    // Compare the frame read in the previous cycle.
    if (cmp_en_r) begin
      if (valid_rd && (rd_page_r == page_r) && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      if (!valid_rd && !inv_found_r) begin
        inv_found_r <= 1'b1;
        inv_idx_r   <= cmp_idx_r;
      end
      if (rank_rd < min_rank_r) begin
        min_rank_r <= rank_rd;
        min_idx_r  <= cmp_idx_r;
      end
    end
    // Reduce the FIFO pointer below the frame count, one subtraction a step.
    if (ctrl.mod_step && stat.mod_more) begin
      victim_r <= prfl_pkg::FIDX_W'(prfl_pkg::CNT_W'(victim_r) - n);
    end
    if (ctrl.pick) begin
      if (hit_r) begin
        frame_r <= hit_idx_r;
      end else if (policy == prfl_pkg::POL_LRU) begin
        frame_r <= inv_found_r ? inv_idx_r : min_idx_r;
      end else begin
        frame_r <= victim_r;
      end
    end
    if (ctrl.ev_rd) begin
      ev_valid_r <= !hit_r && valid_rd;
    end
  end

  // Architectural state and the compare enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fifo_ptr_r <= '0;
      faults_r   <= '0;
      writes_r   <= '0;
      cmp_en_r   <= 1'b0;
      for (int k = 0; k < prfl_pkg::FRAMES; k++) begin
        rank_r[k] <= prfl_pkg::FIDX_W'(k);
      end
    end else begin
      cmp_en_r <= ctrl.scan;
      if (load && in_is_write && (writes_r != '1)) begin
        writes_r <= writes_r + 1'b1;
      end
      if (ctrl.commit) begin
        if (!hit_r) begin
          valid_r[frame_r] <= 1'b1;
          faults_r         <= faults_inc;
          if (policy == prfl_pkg::POL_FIFO) begin
            fifo_ptr_r <= fifo_ptr_nxt;
          end
        end
        // Move the used frame to the top of the recency order.
        if (policy == prfl_pkg::POL_LRU) begin
          for (int k = 0; k < prfl_pkg::FRAMES; k++) begin
            if (prfl_pkg::FIDX_W'(k) == frame_r) begin
              rank_r[k] <= prfl_pkg::FIDX_W'(prfl_pkg::FRAMES - 1);
            end else if (rank_r[k] > rank_rd) begin
              rank_r[k] <= rank_r[k] - 1'b1;
            end
          end
        end
      end
    end
  end

  // Result of the item, taken by the output register at commit.
  always_comb begin
    res.hit           = hit_r;
    res.frame_index   = prfl_pkg::FRAME_OUT_W'(frame_r);
    res.evicted_valid = ev_valid_r;
    res.evicted_page  = ev_valid_r ? prfl_pkg::PAGE_W'(rd_page_r) : '0;
    res.fault_count   = hit_r ? faults_r : faults_inc;
    res.write_count   = writes_r;
  end

  // Exactly one frame holds the most recent rank.
  always_comb begin
    for (int k = 0; k < prfl_pkg::FRAMES; k++) begin
      top_rank[k] = (rank_r[k] == prfl_pkg::FIDX_W'(prfl_pkg::FRAMES - 1));
    end
  end

  `PRFL_ASSERT(a_rank_top, $onehot(top_rank), "recency ranks lost their order")
  `PRFL_ASSERT(a_hit_range, (ctrl.commit && hit_r) |-> (prfl_pkg::CNT_W'(frame_r) < n), "hit outside the frames in use")
  `PRFL_ASSERT_NEXT(a_fill_valid, ctrl.commit && !hit_r, valid_r[$past(frame_r)], "filled frame not marked valid")
  `PRFL_ASSERT_NEXT(a_fifo_ptr, ctrl.commit && !hit_r && (policy == prfl_pkg::POL_FIFO), prfl_pkg::CNT_W'(fifo_ptr_r) < $past(n), "FIFO pointer left the frames in use")

endmodule
